@@ sv/ssd_pkg.sv @@
// shared types, constants and font table for the seven segment scan driver
package ssd_pkg;

    localparam int BUF_DEPTH_DEF  = 16;
    localparam int MAX_DIGITS_DEF = 8;

    localparam int KIND_W     = 2;
    localparam int POS_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int SHIFT_W    = 8;
    localparam int DIGIT_W    = 8;
    localparam int SEG_W      = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int NDIG_W     = 4;
    localparam int ULEN_W     = 5;

    localparam logic [NDIG_W-1:0] NUM_DIGITS_RST = 4'd4;
    localparam logic [ULEN_W-1:0] USED_LEN_RST   = 5'd16;

    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST  = 8'd126;
    localparam int         GLYPH_COUNT = 95;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_SHIFT = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIGITS   = 2'd0,
        CFG_USED_LENGTH  = 2'd1,
        CFG_COMMON_ANODE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               hit;
        logic               ca;
        logic [DIGIT_W-1:0] en;
    } t_pix;

    localparam logic [7:0] FONT_ROM [GLYPH_COUNT] = '{
        8'h00, 8'h86, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h39, 8'h41,
        8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h40,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h77, 8'h7F, 8'h39, 8'h1F, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30,
        8'h1E, 8'h7A, 8'h38, 8'h55, 8'h76, 8'h3F, 8'h73, 8'h3B, 8'h7B,
        8'h6D, 8'h31, 8'h3E, 8'h2E, 8'h6A, 8'h49, 8'h6E, 8'h5B,
        8'h39, 8'h00, 8'h0F, 8'h21, 8'h08, 8'h00,
        8'h4C, 8'h7C, 8'h58, 8'h5E, 8'h1A, 8'h71, 8'h59, 8'h74, 8'h10,
        8'h0E, 8'h69, 8'h30, 8'h15, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50,
        8'h48, 8'h78, 8'h1C, 8'h0C, 8'h2A, 8'h48, 8'h6E, 8'h48,
        8'h39, 8'h30, 8'h0F, 8'h40
    };

    function automatic logic [SEG_W-1:0] f_glyph(input logic [CHAR_W-1:0] code);
        logic [6:0] ofs;
        begin
            ofs = 7'(code - GLYPH_FIRST);
            if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
                return 8'h00;
            end
            return FONT_ROM[ofs];
        end
    endfunction

endpackage

@@ sv/seven_segment_scan_driver_top.sv @@
// top level of the multiplexed seven segment scan driver
// a tick beat passes through stage one (pixel register and store ram read), then the output register
// throughput: one beat per cycle of any kind unless the output stalls; the text store ram read sets the two stages
// other kinds give no output beat and take effect for the very next beat
// reset (sync, active low) clears scan counter, scroll offset, pipeline valids and
// the per entry valid bits, so every store entry reads blank at once with no clearing pass
module seven_segment_scan_driver_top #(
    parameter int BUF_DEPTH  = ssd_pkg::BUF_DEPTH_DEF,
    parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // position [3:0], char_code [11:4], shift_amount [19:12]
    input  logic [ssd_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // kind [1:0]
    input  logic [ssd_pkg::KIND_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // digit_enable [7:0], segment_lines [15:8]
    output logic [ssd_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import ssd_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [NDIG_W-1:0] r_num_digits;
    logic [ULEN_W-1:0] r_used_len;
    logic              r_com_anode;
    logic              r_s1_vld;

    logic              w_acc;
    logic              w_adv;
    logic              w_out_vld;
    t_kind             w_kind;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [CHAR_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [CHAR_W-1:0] w_rd_data;
    t_pix              w_pix;

    assign w_kind     = t_kind'(i_s_tuser);
    assign w_adv      = !w_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || w_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = w_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_digits <= NUM_DIGITS_RST;
            r_used_len   <= USED_LEN_RST;
            r_com_anode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_DIGITS:   r_num_digits <= i_cfg_data[NDIG_W-1:0];
                CFG_USED_LENGTH:  r_used_len   <= i_cfg_data;
                CFG_COMMON_ANODE: r_com_anode  <= i_cfg_data[0];
                default:          r_com_anode  <= r_com_anode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_acc) begin
            r_s1_vld <= (w_kind == KIND_TICK);
        end else if (w_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    ssd_ctrl #(
        .BUF_DEPTH  (BUF_DEPTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (w_acc),
        .i_kind       (w_kind),
        .i_pos        (i_s_tdata[3:0]),
        .i_char       (i_s_tdata[11:4]),
        .i_shift      (i_s_tdata[19:12]),
        .i_num_digits (r_num_digits),
        .i_used_len   (r_used_len),
        .i_com_anode  (r_com_anode),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .o_pix        (w_pix)
    );

    ssd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ssd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_s1_vld (r_s1_vld),
        .i_pix    (w_pix),
        .i_char   (w_rd_data),
        .o_vld    (w_out_vld),
        .o_data   (o_m_tdata)
    );

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_adv |=> r_s1_vld)
        else $error("stage one beat dropped while stalled");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_s1_vld && w_out_vld && !i_m_tready)
        else $error("input stalled without a full pipeline");

    a_ca_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && w_pix.ca |-> $onehot0(w_pix.en))
        else $error("more than one digit enabled");

endmodule

@@ sv/ssd_ram.sv @@
// generic single port write, registered read ram
module ssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/ssd_ctrl.sv @@
// scan counter, scroll offset, store valid bits and first pipeline stage
module ssd_ctrl #(
    parameter int BUF_DEPTH  = ssd_pkg::BUF_DEPTH_DEF,
    parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS_DEF,
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  ssd_pkg::t_kind               i_kind,
    input  logic [ssd_pkg::POS_W-1:0]    i_pos,
    input  logic [ssd_pkg::CHAR_W-1:0]   i_char,
    input  logic [ssd_pkg::SHIFT_W-1:0]  i_shift,
    input  logic [ssd_pkg::NDIG_W-1:0]   i_num_digits,
    input  logic [ssd_pkg::ULEN_W-1:0]   i_used_len,
    input  logic                         i_com_anode,
    output logic                         o_wr_en,
    output logic [AW-1:0]                o_wr_addr,
    output logic [ssd_pkg::CHAR_W-1:0]   o_wr_data,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    output ssd_pkg::t_pix                o_pix
);

    import ssd_pkg::*;

    logic [SHIFT_W-1:0]   r_offset;
    logic [SHIFT_W-1:0]   n_offset;
    logic [2:0]           r_scan;
    logic [2:0]           n_scan;
    logic [BUF_DEPTH-1:0] r_vld;
    logic [BUF_DEPTH-1:0] n_vld;
    t_pix                 r_pix;
    t_pix                 n_pix;

    logic [NDIG_W-1:0]  w_count;
    logic [NDIG_W-1:0]  w_next;
    logic [DIGIT_W-1:0] w_mask;
    logic [DIGIT_W-1:0] w_onehot;
    logic [8:0]         w_idx;
    logic               w_in_range;
    logic [6:0]         w_pos_ext;
    logic               w_wr_ok;
    logic               w_tick;

    assign w_tick    = i_acc && (i_kind == KIND_TICK);
    assign w_pos_ext = {3'b000, i_pos};
    assign w_wr_ok   = i_acc && (i_kind == KIND_WRITE) && (w_pos_ext < 7'(BUF_DEPTH));

    assign w_count = (i_num_digits > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : i_num_digits;
    assign w_next  = {1'b0, r_scan} + 4'd1;

    always_comb begin
        for (int d = 0; d < DIGIT_W; d++) begin
            w_mask[d]   = 4'(d) < w_count;
            w_onehot[d] = (r_scan == 3'(d)) && w_mask[d];
        end
    end

    // signed store index of the digit being scanned
    assign w_idx = {6'b000000, r_scan} + {r_offset[7], r_offset};
    assign w_in_range = !w_idx[8] && (w_idx[7:0] < {3'b000, i_used_len})
                        && (w_idx[7:0] < 8'(BUF_DEPTH));

    assign o_wr_en   = w_wr_ok;
    assign o_wr_addr = w_pos_ext[AW-1:0];
    assign o_wr_data = i_char;
    assign o_rd_en   = w_tick;
    assign o_rd_addr = w_idx[AW-1:0];
    assign o_pix     = r_pix;

    always_comb begin
        n_offset = r_offset;
        n_scan   = r_scan;
        n_vld    = r_vld;
        n_pix    = r_pix;
        if (i_acc) begin
            unique case (i_kind)
                KIND_TICK: begin
                    n_pix.hit = w_in_range ? r_vld[o_rd_addr] : 1'b0;
                    n_pix.ca  = i_com_anode;
                    n_pix.en  = i_com_anode ? w_onehot : (w_onehot ^ w_mask);
                    n_scan    = (w_next >= w_count) ? 3'd0 : w_next[2:0];
                end
                KIND_WRITE: begin
                    if (w_wr_ok) begin
                        n_vld[o_wr_addr] = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    n_vld = '0;
                end
                KIND_SHIFT: begin
                    n_offset = r_offset - i_shift;
                end
                default: begin
                    n_offset = r_offset;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_scan   <= '0;
            r_vld    <= '0;
        end else begin
            r_offset <= n_offset;
            r_scan   <= n_scan;
            r_vld    <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

endmodule

@@ sv/ssd_out.sv @@
// font lookup, polarity and output register
module ssd_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_s1_vld,
    input  ssd_pkg::t_pix                   i_pix,
    input  logic [ssd_pkg::CHAR_W-1:0]      i_char,
    output logic                            o_vld,
    output logic [ssd_pkg::OUT_DATA_W-1:0]  o_data
);

    import ssd_pkg::*;

    logic                  r_vld;
    logic [OUT_DATA_W-1:0] r_data;
    logic [SEG_W-1:0]      w_pattern;
    logic [SEG_W-1:0]      w_segs;

    assign w_pattern = i_pix.hit ? f_glyph(i_char) : 8'h00;
    assign w_segs    = i_pix.ca ? ~w_pattern : w_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_s1_vld) begin
            r_data <= {w_segs, i_pix.en};
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the seven segment scan driver: directed table, then random phases
module tb_top;

    import ssd_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 75;
    localparam logic [7:0]  BLANK_CHAR   = 8'h3B;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    localparam logic [7:0] GLYPH_SEGS [GLYPH_COUNT] = '{
        8'h00, 8'h86, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h39, 8'h41,
        8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h40,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h77, 8'h7F, 8'h39, 8'h1F, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30,
        8'h1E, 8'h7A, 8'h38, 8'h55, 8'h76, 8'h3F, 8'h73, 8'h3B, 8'h7B,
        8'h6D, 8'h31, 8'h3E, 8'h2E, 8'h6A, 8'h49, 8'h6E, 8'h5B,
        8'h39, 8'h00, 8'h0F, 8'h21, 8'h08, 8'h00,
        8'h4C, 8'h7C, 8'h58, 8'h5E, 8'h1A, 8'h71, 8'h59, 8'h74, 8'h10,
        8'h0E, 8'h69, 8'h30, 8'h15, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50,
        8'h48, 8'h78, 8'h1C, 8'h0C, 8'h2A, 8'h48, 8'h6E, 8'h48,
        8'h39, 8'h30, 8'h0F, 8'h40
    };

    typedef struct packed {
        logic [SEG_W-1:0]   seg;
        logic [DIGIT_W-1:0] en;
    } t_frame;

    typedef struct packed {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        logic [4:0]         reg_val;
        t_kind              kind;
        logic [POS_W-1:0]   pos;
        logic [CHAR_W-1:0]  code;
        logic [SHIFT_W-1:0] amt;
        bit                 typed;
        t_frame             fr;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;
    logic [KIND_W-1:0]      i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // predicted block state
    logic [7:0]  text_copy [BUF_DEPTH_DEF];
    logic [7:0]  view_offset = 8'h00;
    logic [2:0]  scan_pos = 3'd0;
    logic [3:0]  cfg_digits = NUM_DIGITS_RST;
    logic [4:0]  cfg_length = USED_LEN_RST;
    logic        cfg_anode = 1'b0;

    t_frame      digits_due [$];
    bit          steady = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;
    int          n_ticks = 0;
    int          n_writes = 0;
    int          n_shifts = 0;
    int          n_clears = 0;
    int          n_reg_writes = 0;

    seven_segment_scan_driver_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit predict_digit(input t_kind k, input logic [3:0] pos,
                                         input logic [7:0] code, input logic [7:0] amt,
                                         output t_frame fr);
        int         cnt;
        int         mask;
        int         onehot;
        int         idx;
        logic [7:0] ch;
        logic [7:0] pat;
        fr = '0;
        case (k)
            KIND_WRITE: begin
                text_copy[pos] = code;
                return 1'b0;
            end
            KIND_CLEAR: begin
                foreach (text_copy[i]) text_copy[i] = BLANK_CHAR;
                return 1'b0;
            end
            KIND_SHIFT: begin
                view_offset = view_offset - amt;
                return 1'b0;
            end
            default: ;
        endcase
        cnt    = (cfg_digits > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(cfg_digits);
        mask   = (1 << cnt) - 1;
        onehot = (1 << scan_pos) & mask;
        idx    = int'(scan_pos) + int'($signed(view_offset));
        pat    = 8'h00;
        if (idx >= 0 && idx < int'(cfg_length) && idx < BUF_DEPTH_DEF) begin
            ch = text_copy[idx];
            if (ch >= GLYPH_FIRST && ch <= GLYPH_LAST) pat = GLYPH_SEGS[ch - GLYPH_FIRST];
        end
        if (cfg_anode) begin
            fr.en  = 8'(onehot);
            fr.seg = ~pat;
        end else begin
            fr.en  = 8'(onehot ^ mask);
            fr.seg = pat;
        end
        scan_pos = (int'(scan_pos) + 1 >= cnt) ? 3'd0 : scan_pos + 3'd1;
        return 1'b1;
    endfunction

    function automatic t_row beat_row(input t_kind k, input logic [3:0] pos,
                                      input logic [7:0] code, input logic [7:0] amt);
        t_row r;
        r      = '0;
        r.kind = k;
        r.pos  = pos;
        r.code = code;
        r.amt  = amt;
        return r;
    endfunction

    function automatic t_row check_row(input logic [7:0] en, input logic [7:0] seg);
        t_row r;
        r        = '0;
        r.kind   = KIND_TICK;
        r.typed  = 1'b1;
        r.fr.en  = en;
        r.fr.seg = seg;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [4:0] val);
        t_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic send_beat(input t_kind k, input logic [3:0] pos, input logic [7:0] code,
                             input logic [7:0] amt, input bit typed, input t_frame typed_fr);
        int     gap;
        bit     has;
        t_frame fr;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, amt, code, pos};
        i_s_tuser  <= k;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        has = predict_digit(k, pos, code, amt, fr);
        if (has) digits_due.push_back(typed ? typed_fr : fr);
        case (k)
            KIND_TICK:  n_ticks++;
            KIND_WRITE: n_writes++;
            KIND_SHIFT: n_shifts++;
            default:    n_clears++;
        endcase
    endtask

    // drain the pipeline before touching the registers
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_DIGITS:   cfg_digits = val[3:0];
            CFG_USED_LENGTH:  cfg_length = val;
            CFG_COMMON_ANODE: cfg_anode  = val[0];
            default: ;
        endcase
        n_reg_writes++;
        @(posedge i_clk);
    endtask

    // output side: random backpressure and comparison
    initial begin
        int     hold;
        t_frame got;
        t_frame want;
        hold = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                got = o_m_tdata;
                if (digits_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected beat: en %h seg %h", got.en, got.seg);
                    mismatches++;
                end else begin
                    want = digits_due.pop_front();
                    if (got.en !== want.en || got.seg !== want.seg) begin
                        if (mismatches < 10)
                            $display("beat mismatch: en exp %h got %h, seg exp %h got %h",
                                     want.en, got.en, want.seg, got.seg);
                        mismatches++;
                    end
                end
            end
            if (hold > 0) begin
                hold--;
            end else if (steady || $urandom_range(0, 99) < 60) begin
                i_m_tready <= 1'b1;
                hold = $urandom_range(0, 7);
            end else begin
                i_m_tready <= 1'b0;
                hold = pick_gap();
            end
        end
    end

    initial begin
        t_row       plan [$];
        t_row       row;
        int         n;
        int         r;
        logic [4:0] nd_val;
        logic [4:0] ul_val;
        logic [4:0] ca_val;
        logic [7:0] amt;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_TICK;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_NUM_DIGITS;
        i_cfg_data <= '0;
        foreach (text_copy[i]) text_copy[i] = BLANK_CHAR;

        plan.push_back(check_row(8'h0E, 8'h00));
        plan.push_back(beat_row(KIND_WRITE, 4'd0, 8'h30, 8'h00));
        plan.push_back(beat_row(KIND_WRITE, 4'd15, 8'hFF, 8'hFF));
        plan.push_back(beat_row(KIND_WRITE, 4'd1, 8'h7E, 8'h00));
        plan.push_back(beat_row(KIND_WRITE, 4'd2, 8'h20, 8'h00));
        plan.push_back(beat_row(KIND_WRITE, 4'd3, 8'h2C, 8'h00));
        repeat (4) plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));
        plan.push_back(cfg_row(CFG_COMMON_ANODE, 5'd1));
        plan.push_back(beat_row(KIND_TICK, 4'hF, 8'hFF, 8'hFF));
        plan.push_back(cfg_row(CFG_NUM_DIGITS, 5'd15));
        plan.push_back(cfg_row(CFG_USED_LENGTH, 5'd1));
        plan.push_back(beat_row(KIND_SHIFT, 4'd0, 8'h00, 8'h80));
        plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));
        plan.push_back(beat_row(KIND_SHIFT, 4'd0, 8'h00, 8'h7F));
        plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));
        plan.push_back(cfg_row(CFG_NUM_DIGITS, 5'd0));
        plan.push_back(check_row(8'h00, 8'hFF));
        plan.push_back(cfg_row(CFG_NUM_DIGITS, 5'd8));
        plan.push_back(cfg_row(CFG_USED_LENGTH, 5'd16));
        plan.push_back(cfg_row(CFG_COMMON_ANODE, 5'd0));
        plan.push_back(cfg_row(CFG_UNUSED, 5'h1F));
        plan.push_back(beat_row(KIND_SHIFT, 4'd0, 8'h00, 8'h01));
        plan.push_back(beat_row(KIND_CLEAR, 4'd0, 8'h00, 8'h00));
        plan.push_back(check_row(8'hFE, 8'h00));
        plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));
        plan.push_back(cfg_row(CFG_NUM_DIGITS, 5'd2));
        plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));
        plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));
        plan.push_back(beat_row(KIND_WRITE, 4'd4, 8'h3B, 8'h00));
        plan.push_back(beat_row(KIND_WRITE, 4'd0, 8'h41, 8'h00));
        plan.push_back(beat_row(KIND_TICK, 4'd0, 8'h00, 8'h00));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.kind, row.pos, row.code, row.amt, row.typed, row.fr);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            steady = (ph == 2);
            if (ph == 0) begin
                nd_val = 5'd8;
                ul_val = 5'd16;
                ca_val = 5'd1;
            end else if (ph == 1) begin
                nd_val = 5'd1;
                ul_val = 5'd1;
                ca_val = 5'd0;
            end else begin
                nd_val = 5'($urandom_range(0, 31));
                ul_val = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(1, 16))
                                                      : 5'($urandom_range(0, 31));
                ca_val = 5'($urandom_range(0, 31));
            end
            write_reg(CFG_NUM_DIGITS, nd_val);
            write_reg(CFG_USED_LENGTH, ul_val);
            write_reg(CFG_COMMON_ANODE, ca_val);
            if (ph == 3) write_reg(CFG_UNUSED, 5'($urandom_range(0, 31)));

            // bring the scroll window back to the start of the text
            send_beat(KIND_SHIFT, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      view_offset, 1'b0, '0);
            n = 1;
            if ($urandom_range(0, 1) == 1) begin
                for (int p = 0; p < BUF_DEPTH_DEF; p++) begin
                    send_beat(KIND_WRITE, 4'(p), 8'($urandom_range(32, 126)),
                              8'($urandom_range(0, 255)), 1'b0, '0);
                    n++;
                end
            end
            while (n < PHASE_ITEMS) begin
                r   = $urandom_range(0, 99);
                amt = ($urandom_range(0, 3) != 0) ? 8'($signed($urandom_range(0, 6)) - 3)
                                                  : 8'($urandom_range(0, 255));
                send_beat((r < 50) ? KIND_TICK : (r < 78) ? KIND_WRITE :
                          (r < 95) ? KIND_SHIFT : KIND_CLEAR,
                          4'($urandom_range(0, 15)),
                          ($urandom_range(0, 4) != 0) ? 8'($urandom_range(32, 126))
                                                      : 8'($urandom_range(0, 255)),
                          amt, 1'b0, '0);
                n++;
            end
        end

        steady = 1'b0;
        i_s_tvalid <= 1'b0;
        n = 0;
        while (digits_due.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (digits_due.size() != 0) begin
            $display("%0d digit beats never arrived", digits_due.size());
            mismatches += digits_due.size();
        end

        $display("covered %0d scan ticks, %0d character writes, %0d scrolls, %0d clears",
                 n_ticks, n_writes, n_shifts, n_clears);
        $display("over %0d register writes in %0d random settings plus the directed table",
                 n_reg_writes, PHASES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
